// ===== design/dsp_pkg.sv =====
// Shared types, constants and helper functions of the dual servo PWM controller.
package dsp_pkg;

  // Number of servo channels fitted (one or two) and width of the frame counter.
  localparam int SERVO_COUNT = 2;
  localparam int CNT_W       = 16;

  // Width wide enough to compare the counter, its successor and a 16-bit count.
  localparam int WIDE_W = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;

  // Pin bits of the servos that are fitted.
  localparam logic [1:0] PRESENT_MASK = (SERVO_COUNT >= 2) ? 2'b11 : 2'b01;

  // Angle limits and reset values.
  localparam logic [7:0]  ANGLE_FULL   = 8'd180;
  localparam logic [7:0]  ANGLE_HOME   = 8'd90;
  localparam logic [15:0] ZERO_RESET   = 16'd2000;
  localparam logic [15:0] STEP_RESET   = 16'd2844;
  localparam logic [15:0] PERIOD_RESET = 16'd40000;

  // Compare count for the home angle under the reset register values.
  localparam logic [15:0] COMPARE_RESET = 16'(2000 + (90 * 2844) / 256);

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_FLIP = 2'd2,
    REQ_TICK = 2'd3
  } req_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MIN_A  = 3'd0,
    CFG_MAX_A  = 3'd1,
    CFG_MIN_B  = 3'd2,
    CFG_MAX_B  = 3'd3,
    CFG_ZERO   = 3'd4,
    CFG_STEP   = 3'd5,
    CFG_PERIOD = 3'd6
  } cfg_idx_t;

  // Outcome of one angle request for the addressed servo.
  typedef struct packed {
    logic        wr;
    logic [7:0]  angle;
    logic [15:0] compare;
  } calc_res_t;

  // A lower limit beyond full travel falls back to zero.
  function automatic logic [7:0] clamp_min(input logic [7:0] a);
    clamp_min = (a > ANGLE_FULL) ? 8'd0 : a;
  endfunction

  // An upper limit beyond full travel falls back to full travel.
  function automatic logic [7:0] clamp_max(input logic [7:0] a);
    clamp_max = (a > ANGLE_FULL) ? ANGLE_FULL : a;
  endfunction

endpackage

// ===== design/dsp_servo_calc.sv =====
// Angle update and pulse compare computation for one servo request.
module dsp_servo_calc
  import dsp_pkg::*;
(
  input  req_t        req,
  input  logic [7:0]  cur_angle,
  input  logic [7:0]  step_angle,
  input  logic        turn_dir,
  input  logic [7:0]  min_angle,
  input  logic [7:0]  max_angle,
  input  logic [15:0] zero_pulse_counts,
  input  logic [15:0] degree_step_q8,
  output calc_res_t   res
);

  logic [8:0]  sum_ccw;
  logic [7:0]  diff_cw;
  logic [8:0]  centre;
  logic [23:0] product;
  logic [16:0] pulse_sum;

  // Choose the new angle and whether it is taken.
  always_comb begin
    sum_ccw   = {1'b0, cur_angle} + {1'b0, step_angle};
    diff_cw   = cur_angle - step_angle;
    centre    = ({1'b0, min_angle} + {1'b0, max_angle}) >> 1;
    res.wr    = 1'b0;
    res.angle = cur_angle;
    case (req)
      REQ_SET: begin
        res.wr    = 1'b1;
        res.angle = step_angle;
      end
      REQ_MOVE: begin
        if (!turn_dir) begin
          // Clockwise: no underflow and must stay above the lower limit.
          if (step_angle <= cur_angle && diff_cw > min_angle) begin
            res.wr    = 1'b1;
            res.angle = diff_cw;
          end
        end else begin
          // Counterclockwise: no carry out and must stay below the upper limit.
          if (!sum_ccw[8] && sum_ccw < {1'b0, max_angle}) begin
            res.wr    = 1'b1;
            res.angle = sum_ccw[7:0];
          end
        end
      end
      REQ_FLIP: begin
        res.wr    = 1'b1;
        res.angle = ({1'b0, cur_angle} < centre) ? min_angle : max_angle;
      end
      default: begin
        res.wr    = 1'b0;
        res.angle = cur_angle;
      end
    endcase

    // Pulse width for the new angle, saturated to 16 bits.
    product     = {16'd0, res.angle} * {8'd0, degree_step_q8};
    pulse_sum   = {1'b0, zero_pulse_counts} + {1'b0, product[23:8]};
    res.compare = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
  end

endmodule

// ===== design/dual_servo_pwm_controller.sv =====
// Top level of the dual servo PWM controller: request handling, frame timer, pins.
//
//  channel   direction  accepted when                    carries
//  s_axis    in         s_axis_tvalid & s_axis_tready    request or timer tick
//  m_axis    out        m_axis_tvalid & m_axis_tready    pins, angle, compare, moved
//  cfg       in         cfg_we                           limit, pulse or period register
//
// An item is taken into an input register, worked on in one pass through the
// angle logic and its single 8x16 multiplier, and is registered in the result
// register, so one item per cycle is sustained while the output is not stalled.
// An empty input register always takes an item; a full one takes a new item only
// when the result register is empty or its result is taken in the same cycle.
// Reset puts both servos at 90 degrees, the frame counter at zero and both pins
// high. A stalled output holds its item and the input register behind it.
module dual_servo_pwm_controller
  import dsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // angle_value[7:0], turn_dir[8], zero fill
  input  logic [2:0]  s_axis_tuser,   // req_type[1:0], servo_sel[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pin_levels[1:0], selected_angle[9:2],
                                      // compare_count[25:10], moved[26], zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [7:0]  min_angle [2];
  logic [7:0]  max_angle [2];
  logic [15:0] zero_pulse_counts;
  logic [15:0] degree_step_q8;
  logic [15:0] period_counts;

  // Servo and timer state.
  logic [1:0][7:0]  angle_now;
  logic [1:0][15:0] pulse_compare;
  logic [CNT_W-1:0] frame_counter;
  logic [1:0]       pin_state;

  // Input register.
  logic       in_vld;
  req_t       in_req;
  logic       in_sel;
  logic [7:0] in_val;
  logic       in_dir;

  // Result register.
  logic        out_vld;
  logic [1:0]  out_pins;
  logic [7:0]  out_angle;
  logic [15:0] out_compare;
  logic        out_moved;

  logic        out_free;
  logic        proc;
  logic        present;
  logic        is_tick;
  logic        do_write;
  calc_res_t   calc;

  logic [CNT_W:0]   count_inc;
  logic [15:0]      period_eff;
  logic             wrap;
  logic [CNT_W-1:0] frame_counter_next;
  logic [1:0]       pin_state_next;

  // Handshake: the input register moves on whenever the result register is free.
  assign out_free      = !out_vld || m_axis_tready;
  assign proc          = in_vld && out_free;
  assign s_axis_tready = !in_vld || out_free;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {5'd0, out_moved, out_compare, out_angle, out_pins};

  assign present  = (int'(in_sel) < SERVO_COUNT);
  assign is_tick  = (in_req == REQ_TICK);
  assign do_write = !is_tick && present && calc.wr;

  // Angle logic for the addressed servo.
  dsp_servo_calc u_calc (
    .req               (in_req),
    .cur_angle         (angle_now[in_sel]),
    .step_angle        (in_val),
    .turn_dir          (in_dir),
    .min_angle         (min_angle[in_sel]),
    .max_angle         (max_angle[in_sel]),
    .zero_pulse_counts (zero_pulse_counts),
    .degree_step_q8    (degree_step_q8),
    .res               (calc)
  );

  // Frame timer step: wrap raises the pins, a matching compare lowers one.
  always_comb begin
    count_inc  = {1'b0, frame_counter} + {{CNT_W{1'b0}}, 1'b1};
    period_eff = (period_counts == 16'd0) ? 16'd1 : period_counts;
    wrap       = count_inc[CNT_W] ||
                 (WIDE_W'(count_inc) >= WIDE_W'(period_eff));
    frame_counter_next = wrap ? '0 : count_inc[CNT_W-1:0];
    pin_state_next     = wrap ? PRESENT_MASK : pin_state;
    for (int s = 0; s < 2; s++) begin
      if (s < SERVO_COUNT &&
          WIDE_W'(pulse_compare[s]) == WIDE_W'(frame_counter_next)) begin
        pin_state_next[s] = 1'b0;
      end
    end
    pin_state_next = pin_state_next & PRESENT_MASK;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle[0]      <= 8'd0;
      min_angle[1]      <= 8'd0;
      max_angle[0]      <= ANGLE_FULL;
      max_angle[1]      <= ANGLE_FULL;
      zero_pulse_counts <= ZERO_RESET;
      degree_step_q8    <= STEP_RESET;
      period_counts     <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MIN_A:  min_angle[0]      <= clamp_min(cfg_wdata[7:0]);
        CFG_MAX_A:  max_angle[0]      <= clamp_max(cfg_wdata[7:0]);
        CFG_MIN_B:  min_angle[1]      <= clamp_min(cfg_wdata[7:0]);
        CFG_MAX_B:  max_angle[1]      <= clamp_max(cfg_wdata[7:0]);
        CFG_ZERO:   zero_pulse_counts <= cfg_wdata;
        CFG_STEP:   degree_step_q8    <= cfg_wdata;
        CFG_PERIOD: period_counts     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (proc) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req <= req_t'(s_axis_tuser[1:0]);
      in_sel <= s_axis_tuser[2];
      in_val <= s_axis_tdata[7:0];
      in_dir <= s_axis_tdata[8];
    end
  end

  // Servo and timer state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_now[0]     <= ANGLE_HOME;
      angle_now[1]     <= ANGLE_HOME;
      pulse_compare[0] <= COMPARE_RESET;
      pulse_compare[1] <= COMPARE_RESET;
      frame_counter    <= '0;
      pin_state        <= PRESENT_MASK;
    end else if (proc) begin
      if (is_tick) begin
        frame_counter <= frame_counter_next;
        pin_state     <= pin_state_next;
      end else if (do_write) begin
        angle_now[in_sel]     <= calc.angle;
        pulse_compare[in_sel] <= calc.compare;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (proc) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_pins    <= is_tick ? pin_state_next : pin_state;
      out_angle   <= !present ? 8'd0 : (do_write ? calc.angle : angle_now[in_sel]);
      out_compare <= !present ? 16'd0 :
                     (do_write ? calc.compare : pulse_compare[in_sel]);
      out_moved   <= do_write;
    end
  end

  // Reset leaves the timer at the start of a frame with both pins high.
  a_reset_state : assert property (@(posedge clk)
    rst |=> (frame_counter == '0 && pin_state == PRESENT_MASK && !m_axis_tvalid))
    else $error("timer or output not cleared by reset");

  // Every item leaving the input register shows up as a result.
  a_item_delivered : assert property (@(posedge clk) disable iff (rst)
    proc |=> m_axis_tvalid)
    else $error("processed item did not reach the result register");

  // A timer tick never reports a move.
  a_tick_not_moved : assert property (@(posedge clk) disable iff (rst)
    (proc && is_tick) |=> !out_moved)
    else $error("tick reported as a move");

  // A rejected or ignored request leaves both angles untouched.
  a_reject_keeps_angles : assert property (@(posedge clk) disable iff (rst)
    (proc && !do_write) |=> $stable(angle_now) && $stable(pulse_compare))
    else $error("angle changed without a move");

endmodule
